@@ rtl/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner: register
// indexes of the configuration port, pattern storage sizes and the control
// bundle that the top level broadcasts to every match cell.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B1  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B2  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B3  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ALIGNMENT   = 3'd6;

    // Register widths
    localparam int PLEN_W   = 6;
    localparam int ALIGN_W  = 13;
    localparam int PHASE_W  = 12;
    localparam int ADDR_W   = 64;

    // Pattern storage: four 64-bit words hold 32 programmable bytes
    localparam int PAT_WORDS = 4;
    localparam int PAT_BYTES = 32;

    // Alignment clamp limits
    localparam logic [ALIGN_W-1:0] ALIGN_MIN = 13'd1;
    localparam logic [ALIGN_W-1:0] ALIGN_MAX = 13'd4096;

    // Broadcast to every cell for one item
    typedef struct packed {
        logic       advance;   // item accepted this cycle
        logic       first;     // item opens a new region
        logic [7:0] data_byte; // byte under test
    } cell_ctrl_t;

endpackage

@@ rtl/mbps_cell.sv @@
// ----------------------------------------------------------------------------
// mbps_cell
// One pattern position of the scan chain. Holds the live bit of a candidate
// that has matched all earlier positions, tests the incoming byte against its
// pattern byte and hands the surviving bit to the next position.
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mbps_pkg::cell_ctrl_t ctrl,
    input  logic               shift_in,  // live bit from previous position
    input  logic [7:0]         want,      // pattern byte of this position
    input  logic               care,      // 0: wildcard
    input  logic               in_use,    // position below pattern length
    input  logic               tail,      // last position of the pattern
    output logic               shift_out, // live bit for next position
    output logic               hit        // candidate completes here
);
    import mbps_pkg::*;

    logic live_reg;
    logic live_next;
    logic pass;
    logic keep;

    // Byte compare with wildcard
    assign pass = !care || (ctrl.data_byte == want);
    assign keep = shift_in && in_use && pass;
    assign hit  = keep && tail;

    // A completed candidate is retired at the tail position
    assign live_next = keep && !tail;

    // A region start drops everything in flight
    assign shift_out = live_reg && !ctrl.first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            live_reg <= live_next;
        end
    end

endmodule

@@ rtl/masked_byte_pattern_scan.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Wildcard byte signature scanner built as a chain of match cells.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a memory snapshot enter on the in_* channel (valid/ready), one
//   item per byte. first_of_region marks offset zero of a new region and
//   brings its base address in region_base. Every aligned start offset is a
//   candidate; each cell of the chain holds one pattern position and passes
//   live candidates on by one position per accepted byte.
//   When a candidate survives its last pattern position, its address (base
//   plus start offset) is reported on the out_* channel (valid/ready).
//   Throughput: one byte per clock unless a waiting result stalls the input;
//   the chain advances once per accepted item. A match is shown in the cycle
//   after its last byte is accepted, from the output register.
//   Stall: while a result waits and out_ready is low, in_ready is low; a byte
//   is still accepted in the cycle the waiting result is taken.
//   Reset clears the chain, the offset counters and the output valid bit, and
//   loads pattern_len 1, alignment 1, all other registers zero.
//   Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
//   once. The user must write only while no byte is in progress; not enforced.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    // byte input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    input  logic                                first_of_region,
    input  logic [mbps_pkg::ADDR_W-1:0]         region_base,
    // match output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mbps_pkg::ADDR_W-1:0]         match_address
);
    import mbps_pkg::*;

    localparam int LEN_W = ($clog2(MAX_PATTERN + 1) > PLEN_W) ?
                           $clog2(MAX_PATTERN + 1) : PLEN_W;

    // Configuration registers
    logic [PLEN_W-1:0]  pattern_len_reg;
    logic [63:0]        pattern_words_reg [PAT_WORDS];
    logic [PAT_BYTES-1:0] care_mask_reg;
    logic [ALIGN_W-1:0] alignment_reg;

    // Scan state
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [ADDR_W-1:0]  addr_reg;      // base + offset of the next byte
    logic [ADDR_W-1:0]  addr_next;

    // Output register
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  match_address_reg;
    logic [ADDR_W-1:0]  match_address_next;

    logic               in_fire;
    logic [PHASE_W-1:0] phase_cur;
    logic [ALIGN_W-1:0] stride;
    logic [ALIGN_W-1:0] phase_inc;
    logic [LEN_W-1:0]   len_raw;
    logic [LEN_W-1:0]   len_eff;
    logic [ADDR_W-1:0]  addr_cur;
    cell_ctrl_t         ctrl;

    logic [MAX_PATTERN-1:0] shift_in_vec;
    logic [MAX_PATTERN-1:0] shift_out_vec;
    logic [MAX_PATTERN-1:0] hit_vec;
    logic                   hit_any;

    // Handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg <= PLEN_W'(1);
            for (int w = 0; w < PAT_WORDS; w++)
            begin
                pattern_words_reg[w] <= '0;
            end
            care_mask_reg   <= '0;
            alignment_reg   <= ALIGN_MIN;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PATTERN_LEN: pattern_len_reg      <= cfg_data[PLEN_W-1:0];
                REG_PATTERN_B0:  pattern_words_reg[0] <= cfg_data;
                REG_PATTERN_B1:  pattern_words_reg[1] <= cfg_data;
                REG_PATTERN_B2:  pattern_words_reg[2] <= cfg_data;
                REG_PATTERN_B3:  pattern_words_reg[3] <= cfg_data;
                REG_CARE_MASK:   care_mask_reg        <= cfg_data[PAT_BYTES-1:0];
                REG_ALIGNMENT:   alignment_reg        <= cfg_data[ALIGN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective length and stride
    assign len_raw = LEN_W'(pattern_len_reg);
    assign len_eff = (len_raw > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_raw;
    assign stride  = (alignment_reg == '0)      ? ALIGN_MIN :
                     (alignment_reg > ALIGN_MAX) ? ALIGN_MAX : alignment_reg;

    // Region start restarts phase and address
    assign phase_cur = first_of_region ? '0 : phase_reg;
    assign addr_cur  = first_of_region ? region_base : addr_reg;

    // Phase advance with wrap at the stride
    assign phase_inc  = ALIGN_W'(phase_cur) + ALIGN_W'(1);
    assign phase_next = (phase_inc >= stride) ? '0 : phase_inc[PHASE_W-1:0];
    assign addr_next  = addr_cur + ADDR_W'(1);

    // Start address of a completed candidate
    assign match_address_next = addr_cur - ADDR_W'(len_eff) + ADDR_W'(1);

    assign ctrl.advance   = in_fire;
    assign ctrl.first     = first_of_region;
    assign ctrl.data_byte = data_byte;

    // Chain of match cells
    assign shift_in_vec[0] = (phase_cur == '0);

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic [7:0] want;
        logic       care;

        if (k < PAT_BYTES)
        begin : g_prog
            assign want = pattern_words_reg[k / 8][(k % 8) * 8 +: 8];
            assign care = care_mask_reg[k];
        end
        else
        begin : g_wild
            assign want = 8'h00;
            assign care = 1'b0;
        end

        if (k > 0)
        begin : g_link
            assign shift_in_vec[k] = shift_out_vec[k-1];
        end

        mbps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .shift_in  (shift_in_vec[k]),
            .want      (want),
            .care      (care),
            .in_use    (LEN_W'(k) < len_eff),
            .tail      (LEN_W'(k + 1) == len_eff),
            .shift_out (shift_out_vec[k]),
            .hit       (hit_vec[k])
        );
    end

    assign hit_any = |hit_vec;

    // Scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            addr_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= hit_any;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && hit_any)
        begin
            match_address_reg <= match_address_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_address = match_address_reg;

    // Only the tail position can complete a candidate
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell reports a match");

    // A match seen at accept is presented next cycle
    a_hit_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && hit_any) |=> out_valid_reg)
        else $error("match lost between chain and output register");

    // Input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("input stalled without a waiting result");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the masked byte pattern scanner. A short directed
// table (reset defaults, address wrap, wildcard and alignment cases, length
// and alignment clamps) runs first. Random phases with fresh register
// settings follow, mostly made of planted pattern copies with random
// wildcard bytes, some of them corrupted. A built-in scan predictor keeps
// its own chain of live candidates and queues the expected match addresses.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbps_pkg::*;

    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 56;
    localparam int DRAIN       = 4;

    typedef struct {
        bit                     is_reg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        logic [7:0]             b;
        bit                     first;
        logic [ADDR_W-1:0]      base;
        bit                     typed;
        bit                     t_hit;
        logic [ADDR_W-1:0]      t_addr;
    } step_row_t;

    // DUT ports
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             data_byte;
    logic                   first_of_region;
    logic [ADDR_W-1:0]      region_base;
    logic                   out_valid;
    logic                   out_ready;
    logic [ADDR_W-1:0]      match_address;

    // register copies, at their reset values
    logic [PLEN_W-1:0]      plen_r  = 6'd1;
    logic [63:0]            pat_r [PAT_WORDS] = '{default: '0};
    logic [31:0]            care_r  = '0;
    logic [ALIGN_W-1:0]     align_r = 13'd1;

    // scan state: live candidates, region offset, phase and base
    logic [31:0]            live_q   = '0;
    logic [63:0]            offset_q = '0;
    logic [PHASE_W-1:0]     phase_q  = '0;
    logic [ADDR_W-1:0]      base_q   = '0;

    logic [ADDR_W-1:0]      pending_matches [$];
    logic [ADDR_W-1:0]      head_addr;
    step_row_t              plan [$];

    int                     fault_count  = 0;
    int                     items_sent   = 0;
    int                     matches_seen = 0;
    int                     src_idle     = 21;
    int                     dst_idle     = 70;
    int                     hold_left    = 0;

    masked_byte_pattern_scan dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .first_of_region (first_of_region),
        .region_base     (region_base),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .match_address   (match_address)
    );

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("ERROR at %0t ns: %s", $time, msg);
    endfunction

    // append a row to the stimulus table
    function automatic void add_row(input step_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // queue an expected match address
    function automatic void expect_match(input logic [ADDR_W-1:0] a);
        pending_matches.insert(pending_matches.size(), a);
    endfunction

    // pattern length in use, clamped to the chain depth
    function automatic int eff_len();
        int n;
        n = plen_r;
        return (n > PAT_BYTES) ? PAT_BYTES : n;
    endfunction

    // candidate stride, zero read as one and clamped at 4096
    function automatic int eff_stride();
        int s;
        s = align_r;
        if (s == 0)
            s = 1;
        if (s > 4096)
            s = 4096;
        return s;
    endfunction

    // Advance the scan by one byte; returns 1 with the address on a match
    function automatic bit scan_byte(input logic [7:0] b, input bit first,
                                     input logic [ADDR_W-1:0] base,
                                     output logic [ADDR_W-1:0] addr);
        int          len;
        int          stride;
        int          nxt_phase;
        logic [31:0] nxt;
        logic [7:0]  want;
        bit          hit;
        len    = eff_len();
        stride = eff_stride();
        hit    = 1'b0;
        addr   = '0;
        if (first)
        begin
            base_q   = base;
            offset_q = '0;
            phase_q  = '0;
            live_q   = '0;
        end
        // shift candidates one position on, open a new one on aligned offsets
        nxt = {live_q[30:0], phase_q == '0};
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            want = pat_r[k / 8][(k % 8) * 8 +: 8];
            if (k >= len || (care_r[k] && want != b))
                nxt[k] = 1'b0;
        end
        if (len > 0 && nxt[len - 1])
        begin
            hit          = 1'b1;
            addr         = base_q + offset_q - 64'(len - 1);
            nxt[len - 1] = 1'b0;
        end
        live_q   = nxt;
        offset_q = offset_q + 64'd1;
        nxt_phase = int'(phase_q) + 1;
        if (nxt_phase >= stride)
            nxt_phase = 0;
        phase_q = nxt_phase[PHASE_W-1:0];
        return hit;
    endfunction

    function automatic step_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        step_row_t r;
        r        = '{default: '0};
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic step_row_t byte_row(input logic [7:0] b, input bit first,
                                           input logic [ADDR_W-1:0] base);
        step_row_t r;
        r       = '{default: '0};
        r.b     = b;
        r.first = first;
        r.base  = base;
        return r;
    endfunction

    // byte row whose outcome is written out by hand
    function automatic step_row_t want_row(input logic [7:0] b, input bit first,
                                           input logic [ADDR_W-1:0] base,
                                           input bit hit,
                                           input logic [ADDR_W-1:0] addr);
        step_row_t r;
        r        = byte_row(b, first, base);
        r.typed  = 1'b1;
        r.t_hit  = hit;
        r.t_addr = addr;
        return r;
    endfunction

    // Offer one item and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input bit first,
                             input logic [ADDR_W-1:0] base,
                             output bit hit, output logic [ADDR_W-1:0] addr);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        data_byte       <= b;
        first_of_region <= first;
        region_base     <= base;
        do
            @(posedge clk);
        while (!in_ready);
        hit = scan_byte(b, first, base, addr);
        items_sent++;
    endtask

    // Stop offering and let every queued match come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        case (idx)
            REG_PATTERN_LEN: plen_r   = val[PLEN_W-1:0];
            REG_PATTERN_B0:  pat_r[0] = val;
            REG_PATTERN_B1:  pat_r[1] = val;
            REG_PATTERN_B2:  pat_r[2] = val;
            REG_PATTERN_B3:  pat_r[3] = val;
            REG_CARE_MASK:   care_r   = val[31:0];
            REG_ALIGNMENT:   align_r  = val[ALIGN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #400000;
        $display("tb_top failed");
        $finish;
    end

    // Receiver: random stalls plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= dst_idle);
        end
    end

    // Match checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            matches_seen++;
            if (pending_matches.size() == 0)
                note_fault($sformatf("unexpected match_address %h", match_address));
            else
            begin
                head_addr = pending_matches.pop_front();
                if (match_address !== head_addr)
                    note_fault($sformatf("match_address expected %h actual %h",
                                         head_addr, match_address));
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        logic [7:0]        b;
        logic [7:0]        pb;
        logic [7:0]        burst [$];
        bit                hit;
        bit                fresh;
        int                sent;
        int                rlen;
        int                k;
        logic [PLEN_W-1:0] len_val;
        logic [ALIGN_W-1:0] align_val;
        logic [31:0]       care_val;

        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_index       = REG_PATTERN_LEN;
        cfg_data        = '0;
        in_valid        = 1'b0;
        data_byte       = '0;
        first_of_region = 1'b0;
        region_base     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: one-byte all-wildcard pattern, every byte matches
        add_row(want_row(8'h00, 1'b0, 64'h0, 1'b1, 64'h0));
        add_row(want_row(8'hFF, 1'b1, '1, 1'b1, '1));
        add_row(want_row(8'h5A, 1'b0, 64'h0, 1'b1, 64'h0));
        // zero length never matches
        add_row(reg_row(REG_PATTERN_LEN, 64'd0));
        add_row(want_row(8'h00, 1'b1, 64'h1000, 1'b0, 64'h0));
        // AA ?? CC with a wildcard in the middle, stride 2
        add_row(reg_row(REG_PATTERN_LEN, 64'd3));
        add_row(reg_row(REG_PATTERN_B0, 64'h0000_0000_00CC_00AA));
        add_row(reg_row(REG_CARE_MASK, 64'h5));
        add_row(reg_row(REG_ALIGNMENT, 64'd2));
        add_row(byte_row(8'hAA, 1'b1, 64'h2000));
        add_row(byte_row(8'h37, 1'b0, 64'h0));
        add_row(want_row(8'hCC, 1'b0, 64'h0, 1'b1, 64'h2000));
        // unaligned copy is skipped
        add_row(byte_row(8'hAA, 1'b0, 64'h0));
        add_row(byte_row(8'h11, 1'b0, 64'h0));
        add_row(byte_row(8'hCC, 1'b0, 64'h0));
        // candidate cut by a region start
        add_row(byte_row(8'hAA, 1'b1, 64'h3000));
        add_row(byte_row(8'h11, 1'b0, 64'h0));
        add_row(byte_row(8'hCC, 1'b1, 64'h4000));
        // length above the chain depth, all bytes cared
        add_row(reg_row(REG_PATTERN_LEN, 64'd63));
        add_row(reg_row(REG_CARE_MASK, 64'hFFFF_FFFF));
        add_row(reg_row(REG_PATTERN_B1, '1));
        add_row(reg_row(REG_PATTERN_B2, '1));
        add_row(reg_row(REG_PATTERN_B3, '1));
        add_row(byte_row(8'hFF, 1'b1, 64'h4100));
        add_row(byte_row(8'hAA, 1'b0, 64'h0));
        // alignment clamp to 4096: only offset zero is a candidate
        add_row(reg_row(REG_PATTERN_LEN, 64'd1));
        add_row(reg_row(REG_CARE_MASK, 64'h1));
        add_row(reg_row(REG_PATTERN_B0, 64'h0));
        add_row(reg_row(REG_ALIGNMENT, 64'd8191));
        add_row(want_row(8'h00, 1'b1, 64'h5000, 1'b1, 64'h5000));
        add_row(want_row(8'h00, 1'b0, 64'h0, 1'b0, 64'h0));
        add_row(want_row(8'hFF, 1'b0, 64'h0, 1'b0, 64'h0));
        // alignment zero acts as one
        add_row(reg_row(REG_ALIGNMENT, 64'd0));
        add_row(want_row(8'h00, 1'b1, 64'h6000, 1'b1, 64'h6000));
        add_row(want_row(8'h00, 1'b0, 64'h0, 1'b1, 64'h6001));

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                send_byte(plan[i].b, plan[i].first, plan[i].base, hit, addr);
                if (plan[i].typed)
                begin
                    if (plan[i].t_hit)
                        expect_match(plan[i].t_addr);
                end
                else if (hit)
                    expect_match(addr);
            end
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            src_idle = (ph / 3 == 0) ? 21 : (ph / 3 == 1) ? 70 : 0;
            dst_idle = (ph / 3 == 0) ? 70 : (ph / 3 == 1) ? 21 : 0;

            if (ph == 4)
                len_val = 6'd63;
            else if (ph == 7)
                len_val = 6'd32;
            else
                len_val = 6'($urandom_range(1, 6));
            case ($urandom_range(0, 7))
                0, 1:    align_val = 13'd1;
                2:       align_val = 13'd2;
                3:       align_val = 13'd3;
                4:       align_val = 13'd4;
                5:       align_val = 13'($urandom_range(0, 8191));
                6:       align_val = 13'd4096;
                default: align_val = 13'd0;
            endcase
            case ($urandom_range(0, 3))
                0:       care_val = '1;
                1:       care_val = '0;
                default: care_val = $urandom;
            endcase
            write_reg(REG_PATTERN_LEN, 64'(len_val));
            write_reg(REG_PATTERN_B0, {$urandom, $urandom});
            write_reg(REG_PATTERN_B1, {$urandom, $urandom});
            write_reg(REG_PATTERN_B2, {$urandom, $urandom});
            write_reg(REG_PATTERN_B3, {$urandom, $urandom});
            write_reg(REG_CARE_MASK, 64'(care_val));
            write_reg(REG_ALIGNMENT, 64'(align_val));

            // sometimes the old region runs on under the new setting
            sent  = 0;
            fresh = ($urandom_range(0, 3) != 0);
            while (sent < PHASE_ITEMS)
            begin
                rlen = $urandom_range(1, 2 * eff_len() + 16);
                if ($urandom_range(0, 3) == 0)
                    base = '1 - 64'($urandom_range(0, 40));
                else
                    base = {$urandom, $urandom};
                burst.delete();
                for (int off = 0; off < rlen && sent < PHASE_ITEMS; off++)
                begin
                    // plant a pattern copy at an aligned offset, now and then broken
                    if (burst.size() == 0 && eff_len() > 0 &&
                        off % eff_stride() == 0 && $urandom_range(0, 1) == 1)
                    begin
                        for (int j = 0; j < eff_len(); j++)
                        begin
                            pb = pat_r[j / 8][(j % 8) * 8 +: 8];
                            burst.insert(burst.size(),
                                         care_r[j] ? pb : 8'($urandom_range(0, 255)));
                        end
                        if ($urandom_range(0, 6) == 0)
                        begin
                            k = $urandom_range(0, eff_len() - 1);
                            burst[k] = burst[k] ^ 8'($urandom_range(1, 255));
                        end
                    end
                    if (burst.size() != 0)
                        b = burst.pop_front();
                    else
                        b = 8'($urandom_range(0, 255));
                    send_byte(b, fresh && off == 0, base, hit, addr);
                    if (hit)
                        expect_match(addr);
                    sent++;
                    if (ph == 0 && sent == 10)
                        hold_left = 300;
                    if (ph == 2 && sent == 28)
                        wait_idle();
                end
                fresh = 1'b1;
            end
        end

        wait_idle();
        while (pending_matches.size() != 0)
        begin
            head_addr = pending_matches.pop_front();
            note_fault($sformatf("match %h never came out", head_addr));
        end

        $display("Scanned %0d bytes over %0d random register settings plus directed cases;",
                 items_sent, PHASES);
        $display("%0d match addresses checked, %0d faults.", matches_seen, fault_count);
        if (fault_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
